// ===== hw/rtl/caf_pkg.sv =====
package caf_pkg;

	// largest column the block is built for
	localparam int MAX_HEIGHT = 64;

	// register map, index taken from paddr[2]
	localparam logic REG_COLUMN_HEIGHT = 1'b0;

	// column_height after reset
	localparam logic [6:0] HEIGHT_RESET = 7'd64;

	// altitude code for no surface below
	localparam logic signed [6:0] NO_SURFACE = -7'sd1;

	// one pending burst: a run of labelled voxels, then the closing voxel
	typedef struct packed {
		logic [5:0]        run_level;
		logic [6:0]        run_left;
		logic signed [6:0] run_alt;
		logic [5:0]        fin_level;
		logic signed [6:0] fin_alt;
		logic              fin_end;
	} burst_t;

endpackage

// ===== hw/rtl/column_altitude_fill_core.sv =====
// Altitude labelling of voxel columns. Occupancy bits stream in on the item
// channel from level 0 upward, one column after another; column_height (APB
// register at address 0, values 0 and above MAX_HEIGHT are clamped) sets the
// column size. Every voxel yields exactly one result on the result channel:
// occupied voxels are held back as a count and come out as a burst, in rising
// level order, when their run ends at a free voxel or at the ceiling, followed
// by the voxel that ended it. Items are taken at one per cycle but for the wait
// below; a burst's first result is offered in the cycle after its closing voxel
// is taken. A voxel ending a run of n occupied voxels produces n+1 results, one
// per cycle unless stalled, from a single burst register; occupied voxels inside
// a run are still taken while a burst drains, but the next free or top voxel
// waits until the burst's last result is taken in that same cycle or earlier.
module column_altitude_fill_core #(
	parameter int MAX_HEIGHT = caf_pkg::MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// voxel items
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               occupied,
	// results
	output logic               result_valid,
	input  logic               result_ready,
	output logic [5:0]         level,
	output logic signed [6:0]  altitude,
	output logic               column_end,
	output logic               burst_last
);

	logic [6:0]        height_q;
	logic [5:0]        cur_level_q;
	logic [6:0]        pending_q;
	logic [5:0]        run_start_q;
	logic signed [6:0] surface_q;
	caf_pkg::burst_t   burst_q;
	logic              burst_valid_q;

	logic [6:0]        height_eff;
	logic [5:0]        top_level;
	logic              at_top;
	logic              creates;
	logic              in_fire;
	logic              out_fire;
	logic              run_done;
	logic [5:0]        run_begin;
	logic signed [6:0] surf_new;
	caf_pkg::burst_t   burst_d;

	// register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == caf_pkg::REG_COLUMN_HEIGHT) ? {25'd0, height_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= caf_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == caf_pkg::REG_COLUMN_HEIGHT) begin
			height_q <= pwdata[6:0];
		end
	end

	// clamped height and ceiling check
	always_comb begin
		height_eff = height_q;
		if (height_q == 7'd0) begin
			height_eff = 7'd1;
		end else if (height_q > 7'(MAX_HEIGHT)) begin
			height_eff = 7'(MAX_HEIGHT);
		end
	end

	assign top_level = 6'(height_eff - 7'd1);
	assign at_top    = cur_level_q >= top_level;

	// handshake: only a run-closing voxel needs the burst register
	assign run_done     = (burst_q.run_left == 7'd0);
	assign creates      = !occupied || at_top;
	assign item_ready   = !burst_valid_q || (result_ready && run_done) || !creates;
	assign in_fire      = item_valid && item_ready;
	assign result_valid = burst_valid_q;
	assign out_fire     = result_valid && result_ready;

	// burst descriptor for the current voxel
	assign run_begin = (pending_q == 7'd0) ? cur_level_q : run_start_q;
	assign surf_new  = (pending_q != 7'd0) ?
		signed'(7'({1'b0, run_start_q} + pending_q - 7'd1)) : surface_q;

	always_comb begin
		burst_d.run_level = run_begin;
		burst_d.run_left  = pending_q;
		burst_d.run_alt   = occupied ? signed'({1'b0, cur_level_q}) : surf_new;
		burst_d.fin_level = cur_level_q;
		burst_d.fin_alt   = occupied ? signed'({1'b0, cur_level_q}) : surf_new;
		burst_d.fin_end   = at_top;
	end

	// column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_level_q <= 6'd0;
			pending_q   <= 7'd0;
			run_start_q <= 6'd0;
			surface_q   <= caf_pkg::NO_SURFACE;
		end else if (in_fire) begin
			if (at_top) begin
				cur_level_q <= 6'd0;
				pending_q   <= 7'd0;
				run_start_q <= 6'd0;
				surface_q   <= caf_pkg::NO_SURFACE;
			end else if (occupied) begin
				cur_level_q <= cur_level_q + 6'd1;
				pending_q   <= pending_q + 7'd1;
				run_start_q <= run_begin;
			end else begin
				cur_level_q <= cur_level_q + 6'd1;
				pending_q   <= 7'd0;
				surface_q   <= surf_new;
			end
		end
	end

	// burst register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
		end else if (in_fire && creates) begin
			burst_valid_q <= 1'b1;
		end else if (out_fire && run_done) begin
			burst_valid_q <= 1'b0;
		end
	end

	// burst payload, run part counts down one result per transaction
	always_ff @(posedge clk) begin
		if (in_fire && creates) begin
			burst_q <= burst_d;
		end else if (out_fire && !run_done) begin
			burst_q.run_left  <= burst_q.run_left - 7'd1;
			burst_q.run_level <= burst_q.run_level + 6'd1;
		end
	end

	// result fields
	assign level      = run_done ? burst_q.fin_level : burst_q.run_level;
	assign altitude   = run_done ? burst_q.fin_alt : burst_q.run_alt;
	assign column_end = run_done ? burst_q.fin_end : 1'b0;
	assign burst_last = run_done;

	// held-back run always ends just below the current level
	assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != 7'd0) |-> (7'({1'b0, run_start_q} + pending_q) == {1'b0, cur_level_q}))
		else $error("pending run does not end below current level");

	// a new burst only overwrites one whose last result leaves now
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && creates && burst_valid_q) |-> (result_ready && run_done))
		else $error("burst overwritten before it drained");

	// last result taken with no new burst leaves the channel empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && run_done && !(in_fire && creates)) |=> !result_valid)
		else $error("result valid after burst drained");

	// run results count down while the closing voxel waits
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !run_done) |=> (result_valid &&
			burst_q.run_left == $past(burst_q.run_left) - 7'd1))
		else $error("burst run count did not step");

endmodule

// ===== tb/column_altitude_fill_core_tb.sv =====
`timescale 1ns / 1ps

module column_altitude_fill_core_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	// one labelled voxel as it leaves the block
	typedef struct packed {
		logic [5:0]        level;
		logic signed [6:0] altitude;
		logic              column_end;
		logic              burst_last;
	} voxel_label_t;

	// column labelling predictor and store of labels still to come
	class altitude_scoreboard;
		bit [6:0]          height_reg;
		bit [5:0]          cur_level;
		bit [6:0]          run_count;
		bit [5:0]          run_start;
		logic signed [6:0] surface;
		voxel_label_t      pending_labels[$];
		int                errors;

		function new();
			height_reg = caf_pkg::HEIGHT_RESET;
			errors = 0;
			clear_column();
		endfunction

		function void clear_column();
			cur_level = '0;
			run_count = '0;
			run_start = '0;
			surface = caf_pkg::NO_SURFACE;
		endfunction

		function void set_height(bit [6:0] h);
			height_reg = h;
		endfunction

		function int outstanding();
			return pending_labels.size();
		endfunction

		function void push_label(bit [5:0] lvl, logic signed [6:0] alt, bit col_end);
			voxel_label_t lab;
			lab.level = lvl;
			lab.altitude = alt;
			lab.column_end = col_end;
			lab.burst_last = 1'b0;
			pending_labels.insert(pending_labels.size(), lab);
		endfunction

		// work out the labels released by one accepted voxel
		function void note_voxel(bit occ);
			int h;
			int i;
			bit [5:0] top;
			bit [5:0] lvl;
			bit at_top;
			h = height_reg;
			if (h < 1) h = 1;
			if (h > caf_pkg::MAX_HEIGHT) h = caf_pkg::MAX_HEIGHT;
			top = 6'(h - 1);
			lvl = cur_level;
			at_top = (lvl >= top);
			if (occ) begin
				if (run_count == 0) run_start = lvl;
				// inside a run: the count and level grow, no label is released
				if (!at_top) begin
					run_count++;
					cur_level = lvl + 6'd1;
					return;
				end
				// run hits the ceiling
				for (i = 0; i < run_count; i++)
					push_label(run_start + 6'(i), 7'(lvl), 1'b0);
				push_label(lvl, 7'(lvl), 1'b1);
			end else begin
				// free voxel closes any pending run
				if (run_count != 0) begin
					surface = 7'(run_start) + run_count - 7'd1;
					for (i = 0; i < run_count; i++)
						push_label(run_start + 6'(i), surface, 1'b0);
					run_count = '0;
				end
				push_label(lvl, surface, at_top);
			end
			pending_labels[pending_labels.size() - 1].burst_last = 1'b1;
			if (at_top)
				clear_column();
			else
				cur_level = lvl + 6'd1;
		endfunction

		// compare one accepted label with the oldest expectation
		function void check_result(logic [5:0] lvl, logic signed [6:0] alt,
				logic col_end, logic last);
			voxel_label_t want;
			if (pending_labels.size() == 0) begin
				$error("unexpected result: level %0d altitude %0d", lvl, alt);
				errors++;
				return;
			end
			want = pending_labels.pop_front();
			if (lvl !== want.level) begin
				$error("level: expected %0d, actual %0d", want.level, lvl);
				errors++;
			end
			if (alt !== want.altitude) begin
				$error("altitude: expected %0d, actual %0d", want.altitude, alt);
				errors++;
			end
			if (col_end !== want.column_end) begin
				$error("column_end: expected %0d, actual %0d", want.column_end, col_end);
				errors++;
			end
			if (last !== want.burst_last) begin
				$error("burst_last: expected %0d, actual %0d", want.burst_last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              item_valid;
	logic              item_ready;
	logic              occupied;
	logic              result_valid;
	logic              result_ready;
	logic [5:0]        level;
	logic signed [6:0] altitude;
	logic              column_end;
	logic              burst_last;

	altitude_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	column_altitude_fill_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.occupied(occupied),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.level(level),
		.altitude(altitude),
		.column_end(column_end),
		.burst_last(burst_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// random backpressure on the result side
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (item_valid && item_ready) begin
				sb.note_voxel(occupied);
				quiet_cycles = 0;
			end
			if (result_valid && result_ready) begin
				sb.check_result(level, altitude, column_end, burst_last);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic set_mode(input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
	endtask

	// one voxel transaction, called and left at a falling edge
	task automatic send_voxel(input bit occ);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			occupied <= 1'($urandom);
			@(negedge clk);
		end
		item_valid <= 1'b1;
		occupied <= occ;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_pattern(input logic [63:0] bits, input int count);
		int i;
		for (i = 0; i < count; i++) send_voxel(bits[i]);
	endtask

	// stop sending and let every expected label come out
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write of column_height, then read it back
	task automatic write_height(input bit [6:0] h);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {caf_pkg::REG_COLUMN_HEIGHT, 2'b00};
		pwdata <= {25'($urandom), h};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_height(h);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[6:0] !== h) begin
			$error("prdata: expected %0d, actual %0d", h, prdata[6:0]);
			sb.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int phase;
		int i;
		int occ_pct;
		bit [6:0] h;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		occupied = 1'b0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short columns covering each run shape
		set_mode(0, 0);
		write_height(7'd4);
		send_pattern(64'b0000, 4);
		send_pattern(64'b1111, 4);
		send_pattern(64'b0101, 4);
		send_pattern(64'b0110, 4);
		// run left pending, then height drops below the current level
		send_pattern(64'b111, 3);
		drain();
		write_height(7'd2);
		send_voxel(1'b0);
		drain();
		// single-level columns, zero clamps to one
		write_height(7'd1);
		send_pattern(64'b01, 2);
		drain();
		write_height(7'd0);
		send_pattern(64'b10, 2);
		drain();

		// full-height run to the ceiling, oversized height clamps
		set_mode(0, 66);
		write_height(7'd127);
		send_pattern({64{1'b1}}, 64);
		drain();

		// random phases over all idle modes and a spread of heights
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: set_mode(0, 0);
				1: set_mode(66, 0);
				2: set_mode(0, 66);
				default: set_mode(16, 16);
			endcase
			case (phase)
				0, 5: h = 7'($urandom_range(2, 8));
				1: h = 7'd1;
				2: h = 7'd64;
				3: h = 7'($urandom_range(0, 127));
				4: h = 7'd0;
				6: h = 7'd65;
				default: h = 7'($urandom_range(2, 16));
			endcase
			write_height(h);
			case ($urandom_range(0, 3))
				0: occ_pct = 25;
				1: occ_pct = 50;
				2: occ_pct = 80;
				default: occ_pct = 95;
			endcase
			for (i = 0; i < 5; i++) send_voxel($urandom_range(0, 99) < occ_pct);
			drain();
		end

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/caf_pkg.sv
hw/rtl/column_altitude_fill_core.sv
tb/column_altitude_fill_core_tb.sv
